[sv/framed_uart_command_receiver_top_macros.svh]
// ----------------------------------------------------------------------------
// framed uart command receiver assertion macros
// clocked assertion shorthands shared by the receiver top level
// ----------------------------------------------------------------------------
`ifndef FRAMED_UART_COMMAND_RECEIVER_TOP_MACROS_SVH
`define FRAMED_UART_COMMAND_RECEIVER_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define FUCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define FUCR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

[sv/fucr_pkg.sv]
// ----------------------------------------------------------------------------
// fucr_pkg
// shared types and constants of the framed uart command receiver
// ----------------------------------------------------------------------------
package fucr_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = 2;

	localparam logic [2:0] CfgHeadFirst  = 3'd0;
	localparam logic [2:0] CfgHeadSecond = 3'd1;
	localparam logic [2:0] CfgTailByte   = 3'd2;
	localparam logic [2:0] CfgResultType = 3'd3;
	localparam logic [2:0] CfgResultCmd  = 3'd4;
	localparam logic [2:0] CfgMaxPayload = 3'd5;

	localparam logic [7:0]  RstHeadFirst  = 8'hF4;
	localparam logic [7:0]  RstHeadSecond = 8'hF5;
	localparam logic [7:0]  RstTailByte   = 8'hFB;
	localparam logic [7:0]  RstResultType = 8'd160;
	localparam logic [7:0]  RstResultCmd  = 8'd145;
	localparam logic [15:0] RstMaxPayload = 16'd255;

	localparam logic [2:0] StRecognized = 3'd0;
	localparam logic [2:0] StGoodFrame  = 3'd1;
	localparam logic [2:0] StLenBig     = 3'd2;
	localparam logic [2:0] StCksumBad   = 3'd3;
	localparam logic [2:0] StTailBad    = 3'd4;

	typedef enum logic [1:0] {
		EvGood  = 2'd0,
		EvLen   = 2'd1,
		EvCksum = 2'd2,
		EvTail  = 2'd3
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] cmd_id;
		logic [7:0] frame_type;
		logic [7:0] frame_cmd;
	} event_t;

	typedef struct packed {
		logic [7:0]  head_first;
		logic [7:0]  head_second;
		logic [7:0]  tail_byte;
		logic [7:0]  result_type;
		logic [7:0]  result_cmd;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [QAw:0] count;
		logic         full;
		logic         empty;
	} qstat_t;

endpackage

[sv/fucr_front.sv]
// ----------------------------------------------------------------------------
// fucr_front
// byte deframer: tracks the frame layout and emits one event per frame end
// ----------------------------------------------------------------------------
module fucr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  fucr_pkg::cfg_t cfg,
	input  logic           in_accept,
	input  logic [7:0]     rx_byte,
	output logic           ev_push,
	output fucr_pkg::event_t ev
);
	import fucr_pkg::*;

	typedef enum logic [10:0] {
		PsHead0 = 11'b000_0000_0001,
		PsHead1 = 11'b000_0000_0010,
		PsLen0  = 11'b000_0000_0100,
		PsLen1  = 11'b000_0000_1000,
		PsType  = 11'b000_0001_0000,
		PsCmd   = 11'b000_0010_0000,
		PsSeq   = 11'b000_0100_0000,
		PsData  = 11'b000_1000_0000,
		PsCk0   = 11'b001_0000_0000,
		PsCk1   = 11'b010_0000_0000,
		PsTail  = 11'b100_0000_0000
	} parse_state_t;

	parse_state_t state_q, state_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  ck_lo_q, ck_lo_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] len_full;
	logic [15:0] cnt_inc;

	assign len_full = {rx_byte, len_q[7:0]};
	assign cnt_inc  = cnt_q + 16'd1;

	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		ck_lo_d = ck_lo_q;
		type_d  = type_q;
		cmd_d   = cmd_q;
		first_d = first_q;
		ev_push = 1'b0;
		ev      = '{kind: EvGood, cmd_id: first_q, frame_type: type_q, frame_cmd: cmd_q};
		unique case (state_q)
			PsHead1: begin
				if (rx_byte == cfg.head_second) begin
					state_d = PsLen0;
				end else if (rx_byte != cfg.head_first) begin
					state_d = PsHead0;
				end
			end
			PsLen0: begin
				len_d   = {8'd0, rx_byte};
				state_d = PsLen1;
			end
			PsLen1: begin
				len_d = len_full;
				if (len_full <= cfg.max_payload) begin
					state_d = PsType;
				end else begin
					state_d = PsHead0;
					ev_push = in_accept;
					ev      = '{kind: EvLen, cmd_id: 8'd0, frame_type: 8'd0, frame_cmd: 8'd0};
				end
			end
			PsType: begin
				type_d  = rx_byte;
				sum_d   = {8'd0, rx_byte};
				state_d = PsCmd;
			end
			PsCmd: begin
				cmd_d   = rx_byte;
				sum_d   = sum_q + {8'd0, rx_byte};
				state_d = PsSeq;
			end
			PsSeq: begin
				sum_d   = sum_q + {8'd0, rx_byte};
				cnt_d   = 16'd0;
				first_d = 8'd0;
				state_d = (len_q != 16'd0) ? PsData : PsCk0;
			end
			PsData: begin
				if (cnt_q == 16'd0) begin
					first_d = rx_byte;
				end
				cnt_d = cnt_inc;
				sum_d = sum_q + {8'd0, rx_byte};
				if (cnt_inc == len_q) begin
					state_d = PsCk0;
				end
			end
			PsCk0: begin
				ck_lo_d = rx_byte;
				state_d = PsCk1;
			end
			PsCk1: begin
				if ({rx_byte, ck_lo_q} == sum_q) begin
					state_d = PsTail;
				end else begin
					state_d = PsHead0;
					ev_push = in_accept;
					ev.kind = EvCksum;
				end
			end
			PsTail: begin
				state_d = PsHead0;
				ev_push = in_accept;
				ev.kind = (rx_byte == cfg.tail_byte) ? EvGood : EvTail;
			end
			default: begin
				state_d = (rx_byte == cfg.head_first) ? PsHead1 : PsHead0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PsHead0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			ck_lo_q <= '0;
			type_q  <= '0;
			cmd_q   <= '0;
			first_q <= '0;
		end else if (in_accept) begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			ck_lo_q <= ck_lo_d;
			type_q  <= type_d;
			cmd_q   <= cmd_d;
			first_q <= first_d;
		end
	end

endmodule

[sv/fucr_queue.sv]
// ----------------------------------------------------------------------------
// fucr_queue
// small event fifo between the deframer and the result stage
// ----------------------------------------------------------------------------
module fucr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fucr_pkg::event_t push_ev,
	input  logic             pop,
	output fucr_pkg::event_t head_ev,
	output fucr_pkg::qstat_t stat
);
	import fucr_pkg::*;

	event_t         mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   count_q;

	assign head_ev    = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == (QAw+1)'(QDepth));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/fucr_back.sv]
// ----------------------------------------------------------------------------
// fucr_back
// result stage: resolves the status code and holds the outgoing word
// ----------------------------------------------------------------------------
module fucr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fucr_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  fucr_pkg::event_t q_ev,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata
);
	import fucr_pkg::*;

	logic        valid_q;
	logic [26:0] word_q;
	logic [2:0]  status;

	always_comb begin
		unique case (q_ev.kind)
			EvLen:   status = StLenBig;
			EvCksum: status = StCksumBad;
			EvTail:  status = StTailBad;
			default: begin
				status = (q_ev.frame_type == cfg.result_type && q_ev.frame_cmd == cfg.result_cmd)
					? StRecognized : StGoodFrame;
			end
		endcase
	end

	assign q_pop    = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, word_q};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= {q_ev.frame_cmd, q_ev.frame_type, q_ev.cmd_id, status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[sv/framed_uart_command_receiver_top.sv]
// ----------------------------------------------------------------------------
// framed_uart_command_receiver_top
// deframes received serial bytes and reports one word per finished or dropped frame
// a frame-ending byte's event is written into the event fifo, then registered as the result word
// throughput: one byte per cycle while the event fifo is not full
// a four-entry event fifo lets bytes keep flowing while result words wait
// reset: async active low, parser to header wait, registers to default values
// ----------------------------------------------------------------------------
`include "framed_uart_command_receiver_top_macros.svh"

module framed_uart_command_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[2:0], cmd_id[10:3], frame_type[18:11], frame_cmd[26:19]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fucr_pkg::*;

	cfg_t   cfg_q;
	logic   in_accept;
	logic   ev_push;
	event_t ev;
	event_t head_ev;
	qstat_t q_stat;
	logic   q_pop;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_stat.full;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_first  <= RstHeadFirst;
			cfg_q.head_second <= RstHeadSecond;
			cfg_q.tail_byte   <= RstTailByte;
			cfg_q.result_type <= RstResultType;
			cfg_q.result_cmd  <= RstResultCmd;
			cfg_q.max_payload <= RstMaxPayload;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgHeadFirst:  cfg_q.head_first  <= cfg_data[7:0];
				CfgHeadSecond: cfg_q.head_second <= cfg_data[7:0];
				CfgTailByte:   cfg_q.tail_byte   <= cfg_data[7:0];
				CfgResultType: cfg_q.result_type <= cfg_data[7:0];
				CfgResultCmd:  cfg_q.result_cmd  <= cfg_data[7:0];
				CfgMaxPayload: cfg_q.max_payload <= cfg_data;
				default: ;
			endcase
		end
	end

	fucr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_accept (in_accept),
		.rx_byte   (s_tdata),
		.ev_push   (ev_push),
		.ev        (ev)
	);

	fucr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ev_push),
		.push_ev (ev),
		.pop     (q_pop),
		.head_ev (head_ev),
		.stat    (q_stat)
	);

	fucr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (!q_stat.empty),
		.q_ev     (head_ev),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`FUCR_ASSERT(a_q_bound, q_stat.count <= (QAw+1)'(QDepth), "event fifo count over depth")
	`FUCR_ASSERT(a_no_overflow, !(ev_push && q_stat.full), "event pushed into full fifo")
	`FUCR_ASSERT_NEXT(a_push_lands, ev_push, !q_stat.empty, "pushed event missing from fifo")
	`FUCR_ASSERT(a_status_range, !m_tvalid || (m_tdata[2:0] <= StTailBad), "status out of range")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// framed uart command receiver testbench
// drives received bytes as well-formed, flawed, truncated and noisy frames
// under several register settings and idle patterns; a byte-level deframer
// model predicts each report word, and every word is checked field by field
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fucr_pkg::*;

	typedef enum logic [3:0] {
		PsHead0, PsHead1, PsLen0, PsLen1, PsType, PsCmd,
		PsSeq, PsData, PsCk0, PsCk1, PsTail
	} parse_pos_t;

	typedef enum logic [1:0] {FlawNone, FlawLength, FlawCksum, FlawTail} flaw_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] cmd_id;
		logic [7:0] frame_type;
		logic [7:0] frame_cmd;
	} frame_report_t;

	localparam cfg_t DefaultCfg = '{RstHeadFirst, RstHeadSecond, RstTailByte,
		RstResultType, RstResultCmd, RstMaxPayload};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // rx_byte[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // status[2:0], cmd_id[10:3], frame_type[18:11], frame_cmd[26:19]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// deframer model state
	cfg_t        live_cfg = DefaultCfg;
	parse_pos_t  parse_pos = PsHead0;
	logic [15:0] frame_len = '0;
	logic [15:0] data_count = '0;
	logic [15:0] byte_sum = '0;
	logic [7:0]  ck_low = '0;
	logic [7:0]  seen_type = '0;
	logic [7:0]  seen_cmd = '0;
	logic [7:0]  seen_first = '0;

	frame_report_t pending_reports[$];
	logic [7:0]    frame_bytes[$];

	int errors = 0;
	int bytes_sent = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	framed_uart_command_receiver_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void queue_report(input logic [2:0] st, input logic [7:0] id,
			input logic [7:0] ty, input logic [7:0] cm);
		pending_reports.push_back('{st, id, ty, cm});
	endfunction

	function automatic void track_byte(input logic [7:0] c);
		logic [15:0] got;
		case (parse_pos)
		PsHead0: begin
			if (c == live_cfg.head_first) parse_pos = PsHead1;
		end
		PsHead1: begin
			if (c == live_cfg.head_second) parse_pos = PsLen0;
			else if (c != live_cfg.head_first) parse_pos = PsHead0;
		end
		PsLen0: begin
			frame_len = {8'h00, c};
			parse_pos = PsLen1;
		end
		PsLen1: begin
			frame_len[15:8] = c;
			if (frame_len <= live_cfg.max_payload) begin
				parse_pos = PsType;
			end else begin
				parse_pos = PsHead0;
				queue_report(StLenBig, 8'h00, 8'h00, 8'h00);
			end
		end
		PsType: begin
			seen_type = c;
			byte_sum = {8'h00, c};
			parse_pos = PsCmd;
		end
		PsCmd: begin
			seen_cmd = c;
			byte_sum = byte_sum + c;
			parse_pos = PsSeq;
		end
		PsSeq: begin
			byte_sum = byte_sum + c;
			data_count = '0;
			seen_first = '0;
			parse_pos = (frame_len != 0) ? PsData : PsCk0;
		end
		PsData: begin
			if (data_count == 0) seen_first = c;
			data_count = data_count + 16'd1;
			byte_sum = byte_sum + c;
			if (data_count == frame_len) parse_pos = PsCk0;
		end
		PsCk0: begin
			ck_low = c;
			parse_pos = PsCk1;
		end
		PsCk1: begin
			got = {c, ck_low};
			if (got == byte_sum) begin
				parse_pos = PsTail;
			end else begin
				parse_pos = PsHead0;
				queue_report(StCksumBad, seen_first, seen_type, seen_cmd);
			end
		end
		PsTail: begin
			parse_pos = PsHead0;
			if (c != live_cfg.tail_byte)
				queue_report(StTailBad, seen_first, seen_type, seen_cmd);
			else if (seen_type == live_cfg.result_type && seen_cmd == live_cfg.result_cmd)
				queue_report(StRecognized, seen_first, seen_type, seen_cmd);
			else
				queue_report(StGoodFrame, seen_first, seen_type, seen_cmd);
		end
		default: begin
			parse_pos = (c == live_cfg.head_first) ? PsHead1 : PsHead0;
		end
		endcase
	endfunction

	function automatic void build_frame(input logic [7:0] ft, input logic [7:0] fc,
			input logic [15:0] len, input flaw_t flaw);
		logic [7:0]  seq_byte;
		logic [7:0]  data_byte;
		logic [15:0] sum;
		seq_byte = 8'($urandom);
		frame_bytes = {};
		frame_bytes.push_back(live_cfg.head_first);
		frame_bytes.push_back(live_cfg.head_second);
		frame_bytes.push_back(len[7:0]);
		frame_bytes.push_back(len[15:8]);
		if (flaw == FlawLength) return;
		frame_bytes.push_back(ft);
		frame_bytes.push_back(fc);
		frame_bytes.push_back(seq_byte);
		sum = 16'(ft) + 16'(fc) + 16'(seq_byte);
		for (int k = 0; k < int'(len); k++) begin
			data_byte = 8'($urandom);
			frame_bytes.push_back(data_byte);
			sum = sum + data_byte;
		end
		if (flaw == FlawCksum) sum = sum ^ (16'd1 << $urandom_range(15));
		frame_bytes.push_back(sum[7:0]);
		frame_bytes.push_back(sum[15:8]);
		if (flaw == FlawCksum) return;
		if (flaw == FlawTail)
			frame_bytes.push_back(live_cfg.tail_byte ^ 8'($urandom_range(255, 1)));
		else
			frame_bytes.push_back(live_cfg.tail_byte);
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.head_first = 8'($urandom);
		c.head_second = 8'($urandom);
		if ($urandom_range(7) == 0) c.head_second = c.head_first;
		c.tail_byte = 8'($urandom);
		c.result_type = 8'($urandom);
		c.result_cmd = 8'($urandom);
		case ($urandom_range(3))
		0: c.max_payload = 16'($urandom_range(8));
		1: c.max_payload = RstMaxPayload;
		2: c.max_payload = 16'hFFFF;
		default: c.max_payload = 16'($urandom);
		endcase
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		track_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] ft, input logic [7:0] fc,
			input logic [15:0] len, input flaw_t flaw);
		build_frame(ft, fc, len, flaw);
		foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
	endtask

	// run the parser back to the header wait, stop sending, wait for every word
	task automatic settle();
		while (parse_pos != PsHead0) send_byte(8'($urandom));
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		logic [15:0] value;
		for (int i = 0; i < 8; i++) begin
			case (3'(i))
			CfgHeadFirst:  value = {8'h00, c.head_first};
			CfgHeadSecond: value = {8'h00, c.head_second};
			CfgTailByte:   value = {8'h00, c.tail_byte};
			CfgResultType: value = {8'h00, c.result_type};
			CfgResultCmd:  value = {8'h00, c.result_cmd};
			CfgMaxPayload: value = c.max_payload;
			default:       value = 16'($urandom);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= value;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		// indexes past the register list are ignored by the block
		live_cfg = c;
	endtask

	task automatic send_random_frame();
		int          pick;
		int          cut;
		int          short_max;
		logic [15:0] len;
		logic [7:0]  ft;
		logic [7:0]  fc;
		flaw_t       flaw;
		pick = $urandom_range(99);
		short_max = (live_cfg.max_payload < 6) ? int'(live_cfg.max_payload) : 6;
		if (pick < 8) begin
			repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
			return;
		end
		if (pick < 13) begin
			// broken frame, cut off after the length field and before its last byte
			build_frame(8'($urandom), 8'($urandom), 16'($urandom_range(short_max)), FlawNone);
			cut = $urandom_range(frame_bytes.size() - 1, 4);
			for (int k = 0; k < cut; k++) send_byte(frame_bytes[k]);
			return;
		end
		if ($urandom_range(3) == 0) begin
			ft = live_cfg.result_type;
			fc = live_cfg.result_cmd;
		end else begin
			ft = 8'($urandom);
			fc = 8'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 10 && live_cfg.max_payload != 16'hFFFF) flaw = FlawLength;
		else if (pick < 20) flaw = FlawCksum;
		else if (pick < 30) flaw = FlawTail;
		else flaw = FlawNone;
		if (flaw == FlawLength)
			len = 16'($urandom_range(65535, int'(live_cfg.max_payload) + 1));
		else if ($urandom_range(59) == 0 && live_cfg.max_payload <= 300)
			len = live_cfg.max_payload;
		else
			len = 16'($urandom_range(short_max));
		if (live_cfg.head_first != live_cfg.head_second && $urandom_range(9) == 0)
			send_byte(live_cfg.head_first);
		send_frame(ft, fc, len, flaw);
	endtask

	task automatic test_directed();
		send_gap_pct = 0;
		stall_pct = 0;
		send_frame(RstResultType, RstResultCmd, 16'd1, FlawNone);
		send_frame(8'h00, 8'hFF, 16'd0, FlawNone);
		// repeated first header byte
		send_byte(RstHeadFirst);
		send_frame(8'hFF, 8'h00, 16'd2, FlawNone);
		// wrong second header byte
		send_byte(RstHeadFirst);
		send_byte(8'h00);
		send_frame(8'h12, 8'h34, 16'hFFFF, FlawLength);
		send_frame(8'h12, 8'h34, 16'd256, FlawLength);
		send_frame(RstResultType, RstResultCmd, 16'd3, FlawCksum);
		send_frame(RstResultType, RstResultCmd, 16'd0, FlawTail);
		settle();
	endtask

	task automatic test_register_extremes();
		send_gap_pct = 22;
		stall_pct = 22;
		settle();
		load_config('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000});
		send_frame(8'h00, 8'h00, 16'd0, FlawNone);
		send_frame(8'h00, 8'h00, 16'd1, FlawLength);
		send_frame(8'h01, 8'h00, 16'd0, FlawTail);
		send_frame(8'h00, 8'h01, 16'd0, FlawCksum);
		send_frame(8'h01, 8'h02, 16'd0, FlawNone);
		settle();
		load_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
		send_frame(8'hFF, 8'hFF, 16'd2, FlawNone);
		send_frame(8'hFF, 8'hFE, 16'd0, FlawNone);
		send_frame(8'hFF, 8'hFF, 16'd4, FlawTail);
		send_frame(8'h7F, 8'hFF, 16'd1, FlawCksum);
		settle();
	endtask

	// receiver holds off while short dropped frames keep coming in
	task automatic test_output_stall();
		send_gap_pct = 0;
		stall_pct = 0;
		settle();
		load_config(DefaultCfg);
		hold_requests++;
		repeat (40) send_frame(8'($urandom), 8'($urandom),
			16'($urandom_range(65535, int'(RstMaxPayload) + 1)), FlawLength);
		settle();
	endtask

	task automatic test_random_traffic();
		int   goal;
		cfg_t c;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 86; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 86; end
			default: begin send_gap_pct = 22; stall_pct = 22; end
			endcase
			settle();
			c = (phase == 0) ? DefaultCfg : random_cfg();
			load_config(c);
			goal = bytes_sent + 200;
			while (bytes_sent < goal) begin
				send_random_frame();
				if ($urandom_range(149) == 0) settle();
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		frame_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("report word %h with nothing expected", m_tdata);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", {5'd0, want.status}, {5'd0, m_tdata[2:0]});
				check_field("cmd_id", want.cmd_id, m_tdata[10:3]);
				check_field("frame_type", want.frame_type, m_tdata[18:11]);
				check_field("frame_cmd", want.frame_cmd, m_tdata[26:19]);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_output_stall();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/fucr_pkg.sv
sv/fucr_front.sv
sv/fucr_queue.sv
sv/fucr_back.sv
sv/framed_uart_command_receiver_top.sv
tb/sv/testbench.sv
